### rtl/crsf_pkg.sv
`default_nettype none

package crsf_pkg;

    localparam int STORE_BYTES     = 64;
    localparam int NUM_CHANNELS    = 12;
    localparam int CH_BITS         = 11;
    localparam int FIRST_DATA_BYTE = 3;

    localparam int ADDR_W     = $clog2(STORE_BYTES);
    localparam int CNT_W      = $clog2(STORE_BYTES + 1);
    localparam int LEN_CMP_W  = (CNT_W > 8 ? CNT_W : 8) + 1;
    localparam int CH_IDX_W   = 4;
    localparam int RD_BYTES   = (CH_BITS * NUM_CHANNELS + 7) / 8;
    localparam int RD_CNT_W   = $clog2(RD_BYTES + 1);
    localparam int FULL_W     = $clog2(FIRST_DATA_BYTE + RD_BYTES + STORE_BYTES + 1);
    localparam int ACC_W      = CH_BITS + 7;
    localparam int ACC_CNT_W  = $clog2(ACC_W + 1);

    localparam int          PADDR_W       = 3;
    localparam logic        REG_SYNC_BYTE = 1'b0;
    localparam logic [7:0]  SYNC_RESET    = 8'hC8;

    typedef struct packed {
        logic              en;
        logic              clear;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

endpackage

`default_nettype wire

### rtl/crsf_store.sv
`default_nettype none

module crsf_store (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire crsf_pkg::store_wr_t wr,
    input  wire crsf_pkg::store_rd_t rd,
    output logic [7:0]               rd_data
);
    import crsf_pkg::*;

    logic [7:0]             mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] valid_reg;
    logic [STORE_BYTES-1:0] valid_next;
    logic [7:0]             mem_q_reg;
    logic                   hit_reg;

    always_comb begin
        valid_next = wr.clear ? '0 : valid_reg;
        if (wr.en) begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            mem_q_reg <= mem[rd.addr];
            hit_reg   <= rd.in_range && valid_reg[rd.addr];
        end
    end

    assign rd_data = hit_reg ? mem_q_reg : 8'd0;

endmodule

`default_nettype wire

### rtl/crsf_unpack.sv
`default_nettype none

module crsf_unpack (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [31:0]                      tally,
    output crsf_pkg::store_rd_t                   rd,
    input  wire logic [7:0]                       rd_data,
    output logic                                  busy,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [crsf_pkg::CH_IDX_W-1:0]         m_channel_index,
    output logic [crsf_pkg::CH_BITS-1:0]          m_channel_value,
    output logic                                  m_last_channel,
    output logic [31:0]                           m_resync_count
);
    import crsf_pkg::*;

    typedef enum logic [1:0] {
        UNP_IDLE = 2'b01,
        UNP_RUN  = 2'b10
    } unp_state_t;

    unp_state_t            state_reg, state_next;
    logic [RD_CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic                  pend_reg, pend_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [ACC_CNT_W-1:0]  bits_reg, bits_next;
    logic [CH_IDX_W-1:0]   ch_reg, ch_next;

    logic                  m_valid_reg;
    logic [CH_IDX_W-1:0]   idx_reg;
    logic [CH_BITS-1:0]    value_reg;
    logic                  last_reg;
    logic [31:0]           resync_reg;

    logic                  running;
    logic                  out_free;
    logic                  issue;
    logic                  emit;
    logic                  last_ch;
    logic [ACC_CNT_W-1:0]  bits_with_pend;
    logic [ACC_CNT_W-1:0]  base_bits;
    logic [ACC_W-1:0]      shifted;
    logic [FULL_W-1:0]     full_addr;

    assign running        = (state_reg == UNP_RUN);
    assign out_free       = !m_valid_reg || m_ready;
    assign bits_with_pend = bits_reg + (pend_reg ? ACC_CNT_W'(8) : '0);
    assign issue          = running && (rd_ptr_reg < RD_CNT_W'(RD_BYTES))
                            && (bits_with_pend < ACC_CNT_W'(CH_BITS));
    assign emit           = running && (bits_reg >= ACC_CNT_W'(CH_BITS)) && out_free;
    assign last_ch        = (ch_reg == CH_IDX_W'(NUM_CHANNELS - 1));
    assign full_addr      = FULL_W'(FIRST_DATA_BYTE) + FULL_W'(rd_ptr_reg);

    always_comb begin
        rd.en       = issue;
        rd.in_range = (full_addr < FULL_W'(STORE_BYTES));
        rd.addr     = full_addr[ADDR_W-1:0];
    end

    always_comb begin
        shifted   = emit ? (acc_reg >> CH_BITS) : acc_reg;
        base_bits = emit ? (bits_reg - ACC_CNT_W'(CH_BITS)) : bits_reg;
        if (pend_reg) begin
            shifted = shifted | (ACC_W'(rd_data) << base_bits);
        end

        state_next  = state_reg;
        rd_ptr_next = issue ? rd_ptr_reg + RD_CNT_W'(1) : rd_ptr_reg;
        pend_next   = issue;
        acc_next    = shifted;
        bits_next   = base_bits + (pend_reg ? ACC_CNT_W'(8) : '0);
        ch_next     = emit ? ch_reg + CH_IDX_W'(1) : ch_reg;

        unique case (state_reg)
            UNP_IDLE: begin
                if (start) begin
                    state_next  = UNP_RUN;
                    rd_ptr_next = '0;
                    pend_next   = 1'b0;
                    acc_next    = '0;
                    bits_next   = '0;
                    ch_next     = '0;
                end
            end
            UNP_RUN: begin
                if (emit && last_ch) begin
                    state_next = UNP_IDLE;
                end
            end
            default: begin
                state_next = UNP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= UNP_IDLE;
            rd_ptr_reg  <= '0;
            pend_reg    <= 1'b0;
            bits_reg    <= '0;
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_ptr_reg  <= rd_ptr_next;
            pend_reg    <= pend_next;
            bits_reg    <= bits_next;
            ch_reg      <= ch_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (emit) begin
            idx_reg    <= ch_reg;
            value_reg  <= acc_reg[CH_BITS-1:0];
            last_reg   <= last_ch;
            resync_reg <= tally;
        end
    end

    assign busy            = running;
    assign m_valid         = m_valid_reg;
    assign m_channel_index = idx_reg;
    assign m_channel_value = value_reg;
    assign m_last_channel  = last_reg;
    assign m_resync_count  = resync_reg;

endmodule

`default_nettype wire

### rtl/crsf_rc_frame_parser.sv
`default_nettype none

// Byte-serial parser for RC-channels frames. One received byte is accepted per clock
// cycle while s_ready is high. The byte that completes a frame starts the channel unpacker,
// which fetches the 17 packed channel bytes one at a time through the store's single read
// port and emits a channel each time 11 bits have gathered, so s_ready stays low after such
// a transaction until the last channel has been emitted (longer if the result channel
// stalls). The twelve channel transactions leave through an output register, the last one
// with m_last_channel set. The frame store holds per-byte valid bits, so reset and a store
// overflow clear it at once and no clearing pass is needed.
module crsf_rc_frame_parser (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [crsf_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_rx_byte,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [crsf_pkg::CH_IDX_W-1:0]           m_channel_index,
    output logic [crsf_pkg::CH_BITS-1:0]            m_channel_value,
    output logic                                    m_last_channel,
    output logic [31:0]                             m_resync_count
);
    import crsf_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next, phase_eff;
    logic [CNT_W-1:0]   count_reg, count_next, count_eff, count_inc;
    logic [7:0]         len_reg, len_next;
    logic [31:0]        tally_reg, tally_next;
    logic [7:0]         sync_reg;

    logic               accept;
    logic               overflow;
    logic               start;
    logic               busy;
    logic               cfg_write;
    store_wr_t          wr;
    store_rd_t          rd;
    logic [7:0]         rd_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SYNC_BYTE);
    assign prdata    = (paddr[2] == REG_SYNC_BYTE) ? {24'd0, sync_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= SYNC_RESET;
        end else if (cfg_write) begin
            sync_reg <= pwdata[7:0];
        end
    end

    assign s_ready   = !busy;
    assign accept    = s_valid && s_ready;
    assign overflow  = (count_reg >= CNT_W'(STORE_BYTES));
    assign phase_eff = overflow ? PH_HUNT : phase_reg;
    assign count_eff = overflow ? '0 : count_reg;
    assign count_inc = count_eff + CNT_W'(1);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        tally_next = tally_reg;
        start      = 1'b0;
        wr.en      = 1'b0;
        wr.clear   = 1'b0;
        wr.addr    = count_eff[ADDR_W-1:0];
        wr.data    = s_rx_byte;

        if (accept) begin
            tally_next = tally_reg + 32'(overflow);
            wr.clear   = overflow;
            phase_next = phase_eff;
            count_next = count_eff;
            unique case (phase_eff)
                PH_HUNT: begin
                    if (s_rx_byte == sync_reg) begin
                        wr.en      = 1'b1;
                        count_next = count_inc;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    wr.en      = 1'b1;
                    len_next   = s_rx_byte;
                    count_next = count_inc;
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    wr.en = 1'b1;
                    if (LEN_CMP_W'(count_inc) >= (LEN_CMP_W'(len_reg) + LEN_CMP_W'(1))) begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        start      = 1'b1;
                    end else begin
                        count_next = count_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            len_reg   <= '0;
            tally_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            tally_reg <= tally_next;
        end
    end

    crsf_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    crsf_unpack u_unpack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (start),
        .tally           (tally_reg),
        .rd              (rd),
        .rd_data         (rd_data),
        .busy            (busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_last_channel  (m_last_channel),
        .m_resync_count  (m_resync_count)
    );

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import crsf_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int IDLE_LIMIT    = 1000;
    localparam logic [PADDR_W-1:0] SYNC_ADDR = {REG_SYNC_BYTE, 2'b00};

    typedef enum logic [1:0] {
        HUNTING,
        LENGTH_NEXT,
        BODY
    } parse_t;

    typedef struct {
        logic [CH_IDX_W-1:0] index;
        logic [CH_BITS-1:0]  value;
        logic                last;
        logic [31:0]         resync;
    } channel_t;

    typedef struct {
        logic [7:0]         rx;
        int                 count;
        bit                 typed;
        logic [CH_BITS-1:0] typed_value;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_rx_byte = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CH_IDX_W-1:0] m_channel_index;
    logic [CH_BITS-1:0]  m_channel_value;
    logic                m_last_channel;
    logic [31:0]         m_resync_count;

    logic [7:0]  sync_now;
    parse_t      phase_now;
    int unsigned fill_count;
    logic [7:0]  length_now;
    logic [7:0]  store_copy [STORE_BYTES];
    logic [31:0] overflows;

    channel_t channels_due [$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       ready_wait = 0;
    bit       calm = 1'b0;

    row_t directed_rows [7] = '{
        '{8'h00, 1, 1'b0, 11'd0},
        '{8'hC8, 1, 1'b0, 11'd0},
        '{8'h02, 1, 1'b0, 11'd0},
        '{8'h55, 1, 1'b1, 11'd0},
        '{8'hC8, 1, 1'b0, 11'd0},
        '{8'd20, 1, 1'b0, 11'd0},
        '{8'hFF, 19, 1'b1, 11'h7FF}
    };

    crsf_rc_frame_parser uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_last_channel  (m_last_channel),
        .m_resync_count  (m_resync_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void store_put(input int unsigned pos, input logic [7:0] b);
        if (pos < STORE_BYTES) begin
            store_copy[pos] = b;
        end
    endfunction

    function automatic logic [7:0] store_get(input int unsigned pos);
        return (pos < STORE_BYTES) ? store_copy[pos] : 8'h00;
    endfunction

    function automatic void clear_store();
        foreach (store_copy[k]) begin
            store_copy[k] = 8'h00;
        end
    endfunction

    // Follows one accepted byte through the parser and queues the channels it completes.
    function automatic void predict_byte(input logic [7:0] b, input bit typed,
                                         input logic [CH_BITS-1:0] typed_value);
        channel_t    ch;
        int unsigned bitpos;
        int unsigned base;
        logic [23:0] window;
        if (fill_count >= STORE_BYTES) begin
            fill_count = 0;
            phase_now = HUNTING;
            clear_store();
            overflows = overflows + 32'd1;
        end
        case (phase_now)
            HUNTING: begin
                if (b == sync_now) begin
                    store_put(fill_count, b);
                    fill_count = 1;
                    phase_now = LENGTH_NEXT;
                end
            end
            LENGTH_NEXT: begin
                length_now = b;
                store_put(fill_count, b);
                fill_count++;
                phase_now = BODY;
            end
            BODY: begin
                store_put(fill_count, b);
                fill_count++;
                if (fill_count >= int'(length_now) + 1) begin
                    phase_now = HUNTING;
                    fill_count = 0;
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        bitpos = i * CH_BITS;
                        base = FIRST_DATA_BYTE + bitpos / 8;
                        window = {store_get(base + 2), store_get(base + 1), store_get(base)};
                        ch.index = CH_IDX_W'(i);
                        ch.value = typed ? typed_value : CH_BITS'(window >> (bitpos % 8));
                        ch.last = (i == NUM_CHANNELS - 1);
                        ch.resync = overflows;
                        channels_due.push_back(ch);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
            mismatches++;
        end
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (channels_due.size() == 0) begin
                    $display("%0t: unexpected channel transaction, expected none, got index %0d",
                             $time, m_channel_index);
                    mismatches++;
                end else begin
                    check_field("channel_index", channels_due[0].index, m_channel_index);
                    check_field("channel_value", channels_due[0].value, m_channel_value);
                    check_field("last_channel", channels_due[0].last, m_last_channel);
                    check_field("resync_count", channels_due[0].resync, m_resync_count);
                    void'(channels_due.pop_front());
                end
                ready_wait = draw_wait();
                if (ready_wait != 0) begin
                    m_ready <= 1'b0;
                end
            end else if (ready_wait != 0) begin
                ready_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** crsf_rc_frame_parser: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input logic [CH_BITS-1:0] typed_value);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            calm = !calm;
        end
        gap = draw_wait();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, typed, typed_value);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (channels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_sync_byte(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SYNC_ADDR;
        pwdata <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sync_now = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("sync_byte readback", {24'd0, value}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sends one sequence and returns how many bytes it sent as a frame, or zero for a lone byte.
    task automatic send_sequence(output int sent);
        int kind;
        int len;
        int body;
        kind = $urandom_range(0, 9);
        sent = 0;
        if (kind == 0) begin
            send_byte(8'($urandom), 1'b0, '0);
        end else begin
            if (kind == 1) begin
                len = $urandom_range(0, 2);
                body = 1;
            end else if (kind == 2) begin
                len = $urandom_range(3, 63);
                body = $urandom_range(0, len - 2);
            end else if (kind == 3) begin
                len = $urandom_range(3, 63);
                body = len - 1;
            end else begin
                len = $urandom_range(20, 24);
                body = len - 1;
            end
            send_byte(sync_now, 1'b0, '0);
            send_byte(8'(len), 1'b0, '0);
            repeat (body) send_byte(8'($urandom), 1'b0, '0);
            sent = 2 + body;
        end
    endtask

    initial begin
        logic [7:0] settings [3];
        int         sent;
        int         phase_bytes;

        sync_now = SYNC_RESET;
        phase_now = HUNTING;
        fill_count = 0;
        length_now = 8'h00;
        overflows = 32'd0;
        clear_store();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].count; k++) begin
                send_byte(directed_rows[r].rx,
                          directed_rows[r].typed && k == directed_rows[r].count - 1,
                          directed_rows[r].typed_value);
            end
        end
        wait_drained();

        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 3; p++) begin
            set_sync_byte(settings[p]);
            @(posedge aclk);
            if (p == 1) begin
                // A declared length beyond the store fills it, and the next byte overflows.
                send_byte(sync_now, 1'b0, '0);
                send_byte(8'($urandom_range(64, 255)), 1'b0, '0);
                repeat (STORE_BYTES - 2) send_byte(8'($urandom), 1'b0, '0);
            end
            phase_bytes = 0;
            while (phase_bytes < 8) begin
                send_sequence(sent);
                phase_bytes += sent;
            end
            wait_drained();
        end

        if (mismatches == 0 && channels_due.size() == 0) begin
            $display("** crsf_rc_frame_parser: PASSED **");
        end else begin
            $display("** crsf_rc_frame_parser: FAILED **");
        end
        $finish;
    end

endmodule
